// ===== rtl/gdo_pkg.sv =====
// Shared types, constants and calendar helpers for the date offset block.
package gdo_pkg;

    localparam int unsigned MAX_YEAR_DEF = 9999;

    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned OFF_W    = 23;
    localparam int unsigned DNUM_W   = 22;
    // serial counts for years up to 16383 fit in 23 bits; sums with offset and
    // the last day of a 65535-year limit fit in 26 signed bits
    localparam int unsigned SER_W    = 23;
    localparam int unsigned TOT_W    = 26;
    // century count of a 14-bit year, and 400-year count of a 65535-year range
    localparam int unsigned CENT_W   = 8;
    localparam int unsigned Q400_W   = 8;

    localparam int unsigned DAYS_400 = 146097;
    localparam int unsigned DAYS_100 = 36524;
    localparam int unsigned DAYS_4   = 1461;
    localparam int unsigned DAYS_1   = 365;

    // reciprocal multipliers: x / D == (x * MUL) >> SH over the ranges used
    localparam int unsigned DIV100_MUL   = 5243;      // x < 43690
    localparam int unsigned DIV100_SH    = 19;
    localparam int unsigned DIV400Y_MUL  = 15051803;  // x / 146097, x < 2^28
    localparam int unsigned DIV400Y_SH   = 41;
    localparam int unsigned DIV1461_MUL  = 45934;     // x < 94000
    localparam int unsigned DIV1461_SH   = 26;

    // days before the start of each month, common year
    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] r;
        case (m)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // status from the front stage to the split stage
    typedef struct packed {
        logic                valid;
        logic [DNUM_W-1:0]   dnum;
        logic                oor;
        logic [TOT_W-1:0]    n;      // zero-based shifted count
    } front_t;

endpackage

// ===== rtl/gdo_front.sv =====
// Front stages: serial day number of the input date and range test of the shifted count.
module gdo_front
    import gdo_pkg::*;
#(
    parameter int unsigned MAX_YEAR = MAX_YEAR_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic [YEAR_W-1:0]        year,
    input  logic [MONTH_W-1:0]       month,
    input  logic [DAY_W-1:0]         day,
    input  logic signed [OFF_W-1:0]  day_offset,
    output front_t                   out
);
    localparam int unsigned LAST_I = MAX_YEAR * 365 + MAX_YEAR / 4 - MAX_YEAR / 100
                                     + MAX_YEAR / 400;
    localparam logic [TOT_W-1:0] LAST = TOT_W'(LAST_I);

    // stage A: clamp, year-1 and its century count
    logic                     va_reg;
    logic [YEAR_W-1:0]        ym1_reg;
    logic [CENT_W-1:0]        c1_reg;    // (year-1) / 100
    logic [MONTH_W-1:0]       m_reg;
    logic [DAY_W-1:0]         d_reg;
    logic signed [OFF_W-1:0]  off_reg;

    logic [YEAR_W-1:0]  y_c;
    logic [YEAR_W-1:0]  ym1_c;
    logic [MONTH_W-1:0] m_c;
    logic [26:0]        c1_prod_c;

    always_comb begin
        y_c = (year == '0) ? YEAR_W'(1) : year;
        m_c = (month == '0) ? MONTH_W'(1) : ((month > MONTH_W'(12)) ? MONTH_W'(12) : month);
        ym1_c = y_c - YEAR_W'(1);
        // divide by 100 through a reciprocal, exact for every 14-bit year
        c1_prod_c = 27'(ym1_c) * 27'(DIV100_MUL);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (en) begin
            va_reg <= in_valid;
        end
        if (en) begin
            ym1_reg <= ym1_c;
            c1_reg  <= CENT_W'(c1_prod_c >> DIV100_SH);
            m_reg   <= m_c;
            d_reg   <= day;
            off_reg <= day_offset;
        end
    end

    // stage B: serial = days through year-1 + month start + day
    logic               vb_reg;
    logic [SER_W-1:0]   ser_reg;
    logic signed [OFF_W-1:0] offb_reg;

    logic             leap_c;
    logic [SER_W-1:0] ser_c;
    always_comb begin
        // year is ym1+1: multiple of 4 when ym1 is 3 mod 4, of 100 when ym1 is
        // 99 mod 100, and then of 400 when the century count is 3 mod 4
        leap_c = (ym1_reg[1:0] == 2'd3)
               && ((15'(c1_reg) * 15'd100 + 15'd99 != 15'(ym1_reg)) || (c1_reg[1:0] == 2'd3))
               && (m_reg > MONTH_W'(2));
        ser_c = SER_W'(ym1_reg) * SER_W'(365) + SER_W'(ym1_reg >> 2)
              - SER_W'(c1_reg) + SER_W'(c1_reg >> 2)
              + SER_W'(month_start(m_reg)) + SER_W'(d_reg) + SER_W'(leap_c);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
        end else if (en) begin
            vb_reg <= va_reg;
        end
        if (en) begin
            ser_reg  <= ser_c;
            offb_reg <= off_reg;
        end
    end

    // stage C: shifted total and range test
    logic signed [TOT_W-1:0] tot_c;
    always_comb begin
        tot_c = $signed(TOT_W'(ser_reg)) + TOT_W'(offb_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out.valid <= 1'b0;
        end else if (en) begin
            out.valid <= vb_reg;
        end
        if (en) begin
            out.dnum <= ser_reg[DNUM_W-1:0];
            out.oor  <= (tot_c < $signed(TOT_W'(1))) || (tot_c > $signed(LAST));
            out.n    <= tot_c - TOT_W'(1);
        end
    end
endmodule

// ===== rtl/gdo_split.sv =====
// Back stages: break a zero-based day count into year, month and day.
module gdo_split
    import gdo_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  front_t             in,
    output logic               out_valid,
    output logic [DNUM_W-1:0]  dnum,
    output logic [YEAR_W-1:0]  new_year,
    output logic [MONTH_W-1:0] new_month,
    output logic [DAY_W-1:0]   new_day,
    output logic               oor
);
    // stage D: 400-year cycles by reciprocal multiplication
    logic               vd_reg, od_reg;
    logic [DNUM_W-1:0]  dd_reg;
    logic [TOT_W-1:0]   nd_reg;
    logic [Q400_W-1:0]  q400d_reg;
    logic [49:0]        p400_c;
    always_comb begin
        p400_c = 50'(in.n) * 50'(DIV400Y_MUL);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vd_reg <= 1'b0;
        end else if (en) begin
            vd_reg <= in.valid;
        end
        if (en) begin
            od_reg    <= in.oor;
            dd_reg    <= in.dnum;
            nd_reg    <= in.n;
            q400d_reg <= Q400_W'(p400_c >> DIV400Y_SH);
        end
    end

    // stage E: remainder within the 400-year cycle
    logic               ve_reg, oe_reg;
    logic [DNUM_W-1:0]  de_reg;
    logic [Q400_W-1:0]  q400e_reg;
    logic [17:0]        r400_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ve_reg <= 1'b0;
        end else if (en) begin
            ve_reg <= vd_reg;
        end
        if (en) begin
            oe_reg    <= od_reg;
            de_reg    <= dd_reg;
            q400e_reg <= q400d_reg;
            r400_reg  <= 18'(nd_reg - TOT_W'(q400d_reg) * TOT_W'(DAYS_400));
        end
    end

    // stage F: centuries, last one of the cycle holds the extra day
    logic [1:0]  q100_c;
    logic [15:0] r100_c;
    always_comb begin
        if (r400_reg >= 18'(3 * DAYS_100)) begin
            q100_c = 2'd3;
        end else if (r400_reg >= 18'(2 * DAYS_100)) begin
            q100_c = 2'd2;
        end else if (r400_reg >= 18'(DAYS_100)) begin
            q100_c = 2'd1;
        end else begin
            q100_c = 2'd0;
        end
        r100_c = 16'(r400_reg - 18'(q100_c) * 18'(DAYS_100));
    end

    logic               vf_reg, of_reg;
    logic [DNUM_W-1:0]  df_reg;
    logic [Q400_W-1:0]  q400f_reg;
    logic [1:0]         q100f_reg;
    logic [15:0]        r100f_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vf_reg <= 1'b0;
        end else if (en) begin
            vf_reg <= ve_reg;
        end
        if (en) begin
            of_reg    <= oe_reg;
            df_reg    <= de_reg;
            q400f_reg <= q400e_reg;
            q100f_reg <= q100_c;
            r100f_reg <= r100_c;
        end
    end

    // stage G: 4-year groups by reciprocal multiplication
    logic [31:0] p4_c;
    always_comb begin
        p4_c = 32'(r100f_reg) * 32'(DIV1461_MUL);
    end

    logic               vg_reg, og_reg;
    logic [DNUM_W-1:0]  dg_reg;
    logic [Q400_W-1:0]  q400g_reg;
    logic [1:0]         q100g_reg;
    logic [4:0]         q4g_reg;
    logic [15:0]        r100g_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vg_reg <= 1'b0;
        end else if (en) begin
            vg_reg <= vf_reg;
        end
        if (en) begin
            og_reg    <= of_reg;
            dg_reg    <= df_reg;
            q400g_reg <= q400f_reg;
            q100g_reg <= q100f_reg;
            q4g_reg   <= 5'(p4_c >> DIV1461_SH);
            r100g_reg <= r100f_reg;
        end
    end

    // stage H: single years, year number and leap flag
    logic [10:0] r4_c;
    logic [1:0]  q1_c;
    logic [8:0]  r1_c;
    always_comb begin
        r4_c = 11'(r100g_reg - 16'(q4g_reg) * 16'(DAYS_4));
        if (r4_c >= 11'(3 * DAYS_1)) begin
            q1_c = 2'd3;
        end else if (r4_c >= 11'(2 * DAYS_1)) begin
            q1_c = 2'd2;
        end else if (r4_c >= 11'(DAYS_1)) begin
            q1_c = 2'd1;
        end else begin
            q1_c = 2'd0;
        end
        r1_c = 9'(r4_c - 11'(q1_c) * 11'(DAYS_1));
    end

    logic               vh_reg, oh_reg, leap_reg;
    logic [DNUM_W-1:0]  dh_reg;
    logic [16:0]        ny_reg;
    logic [8:0]         ry_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vh_reg <= 1'b0;
        end else if (en) begin
            vh_reg <= vg_reg;
        end
        if (en) begin
            oh_reg   <= og_reg;
            dh_reg   <= dg_reg;
            ny_reg   <= 17'(q400g_reg) * 17'd400 + 17'(q100g_reg) * 17'd100
                      + 17'(q4g_reg) * 17'd4 + 17'(q1_c) + 17'd1;
            ry_reg   <= r1_c;
            // year ends 4-group with q1==3; century year when q4==24 and q1==3
            leap_reg <= (q1_c == 2'd3) && ((q4g_reg != 5'd24) || (q100g_reg == 2'd3));
        end
    end

    // stage I: month from day of year
    logic [3:0] m_c;
    logic [8:0] st_c, bias;
    always_comb begin
        m_c = 4'd1;
        for (int i = 2; i <= 12; i++) begin
            bias = month_start(4'(i)) + ((i > 2 && leap_reg) ? 9'd1 : 9'd0);
            if (ry_reg >= bias) m_c = 4'(i);
        end
        st_c = month_start(m_c) + ((m_c > 4'd2 && leap_reg) ? 9'd1 : 9'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (en) begin
            out_valid <= vh_reg;
        end
        if (en) begin
            dnum      <= dh_reg;
            oor       <= oh_reg;
            new_year  <= oh_reg ? '0 : ny_reg[YEAR_W-1:0];
            new_month <= oh_reg ? '0 : m_c;
            new_day   <= oh_reg ? '0 : DAY_W'(ry_reg - st_c + 9'd1);
        end
    end
endmodule

// ===== rtl/gregorian_date_offset.sv =====
// Top level of the Gregorian date offset pipeline.
//
// Slave channel s_*: one transaction carries a date (year, month, day) and a
// signed day offset. Master channel m_*: one transaction per input carries the
// serial day number of the date (0001-01-01 is day 1), the shifted date and an
// out_of_range flag; the shifted date reads zero when out of range.
//
// Nine register stages: clamp and century count, serial sum, add and range
// test, 400-year quotient, 400-year remainder, century split, 4-year quotient,
// single-year split, month search. The result of an accepted input passes
// through all nine before m_tvalid rises. One transaction is accepted per
// cycle while the output moves.
// The pipeline advances as a whole: when m_tready is low and the last stage
// holds a result, every stage holds and s_tready falls; nothing is lost.
// Reset (aresetn low, synchronous) clears all valid bits.
module gregorian_date_offset
    import gdo_pkg::*;
#(
    parameter int unsigned MAX_YEAR = MAX_YEAR_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // year[13:0], month[17:14], day[22:18], day_offset[45:23]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // day_number[21:0], new_year[35:22], new_month[39:36],
                                   // new_day[44:40], out_of_range[45]
);
    logic en;
    front_t front;
    logic [DNUM_W-1:0]  dnum;
    logic [YEAR_W-1:0]  ny;
    logic [MONTH_W-1:0] nm;
    logic [DAY_W-1:0]   nd;
    logic               oor;

    assign en       = m_tready || !m_tvalid;
    assign s_tready = en;

    gdo_front #(.MAX_YEAR(MAX_YEAR)) u_front (
        .aclk, .aresetn, .en,
        .in_valid   (s_tvalid),
        .year       (s_tdata[13:0]),
        .month      (s_tdata[17:14]),
        .day        (s_tdata[22:18]),
        .day_offset ($signed(s_tdata[45:23])),
        .out        (front)
    );

    gdo_split u_split (
        .aclk, .aresetn, .en,
        .in        (front),
        .out_valid (m_tvalid),
        .dnum, .new_year(ny), .new_month(nm), .new_day(nd), .oor
    );

    assign m_tdata = {2'b00, oor, nd, nm, ny, dnum};
endmodule
